// ----- rtl/rrp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types, widths and codes of the round-robin pairing block.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Field widths.
  localparam int NODE_W = 10;
  localparam int SLOT_W = 10;
  // Node count and ring positions need one bit more than a node id.
  localparam int IDX_W  = NODE_W + 1;

  // Default table depth.
  localparam int MAX_NODES_DEF = 1024;

  // Depth of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 1'b1;

  // Operation codes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One classified word as it travels through the queue.
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [NODE_W-1:0] value;
  } item_t;

endpackage

// ----- rtl/rrp_front.sv -----
// ----------------------------------------------------------------------------
// rrp_front
// Input side: accepts words, drops loads that fall outside the table and
// holds the rest in a short queue for the back end.
// ----------------------------------------------------------------------------
module rrp_front import rrp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [NODE_W-1:0] node_value_i,
  output logic              item_valid_o,
  output item_t             item_o,
  input  logic              item_pop_i
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               accept;
  logic               keep;
  logic               push;
  logic               pop;
  item_t              item_in;

  // Classify the incoming word; a load beyond the table has no effect.
  always_comb begin
    item_in.op    = op_e'(opcode_i);
    item_in.slot  = slot_i;
    item_in.value = node_value_i;
    keep = (item_in.op == OP_QUERY) || ({22'b0, slot_i} < 32'(MAX_NODES));
  end

  assign in_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign accept       = in_valid_i && in_ready_o;
  assign push         = accept && keep;
  assign pop          = item_pop_i && (count_q != '0);
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- rtl/rrp_rem.sv -----
// ----------------------------------------------------------------------------
// rrp_rem
// Restoring remainder unit: reduces a round number modulo the ring size,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rrp_rem import rrp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SLOT_W-1:0] dividend_i,
  input  logic [IDX_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  rem_o
);

  localparam int CNT_W = $clog2(SLOT_W + 1);

  logic              active_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] dvd_q;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [IDX_W:0]    trial;

  assign done_o = active_q && (cnt_q == '0);
  assign rem_o  = rem_q;

  // One step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[SLOT_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = IDX_W'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = IDX_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      cnt_q    <= CNT_W'(SLOT_W);
    end else if (done_o) begin
      active_q <= 1'b0;
    end else if (active_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Dividend shift register and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (active_q && (cnt_q != '0)) begin
      dvd_q <= {dvd_q[SLOT_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

// ----- rtl/rrp_back.sv -----
// ----------------------------------------------------------------------------
// rrp_back
// Execution side: holds the order table, the configuration and the self
// position, carries out loads and works out the partner for each query.
// ----------------------------------------------------------------------------
module rrp_back import rrp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NODE_W-1:0]     partner_id_o,
  output logic                  direction_o,
  output logic                  found_o
);

  localparam int AW         = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int HALF_NODES = MAX_NODES / 2;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_QPOS = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [NODE_W-1:0] pair_count_q;
  logic [NODE_W-1:0] self_id_q;
  logic [NODE_W-1:0] self_pos_q;
  logic              self_seen_q;
  logic              out_valid_q;
  logic [NODE_W-1:0] partner_q;
  logic              dir_out_q;
  logic              found_out_q;

  logic [NODE_W-1:0] table_mem [MAX_NODES];
  logic [NODE_W-1:0] rd_data_q;

  logic [NODE_W-1:0] pc_eff;
  logic [IDX_W-1:0]  node_cnt;
  logic [IDX_W-1:0]  ring_len;
  logic              rem_start;
  logic              rem_done;
  logic [IDX_W-1:0]  rem_val;
  logic [IDX_W-1:0]  r_q;
  logic [IDX_W-1:0]  q_q, q_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              dir_q, dir_d;
  logic [IDX_W:0]    qsum;
  logic [IDX_W:0]    tsum;
  logic [IDX_W-1:0]  t_red;
  logic              do_load;
  logic              out_free;

  // Effective pair count, node count and ring length.
  always_comb begin
    pc_eff = pair_count_q;
    if (pair_count_q == '0) begin
      pc_eff = NODE_W'(1);
    end else if (32'(pair_count_q) > 32'(HALF_NODES)) begin
      pc_eff = NODE_W'(HALF_NODES);
    end
  end
  assign node_cnt = {pc_eff, 1'b0};
  assign ring_len = node_cnt - IDX_W'(1);

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign do_load    = item_pop_o && (item_i.op == OP_LOAD);
  assign rem_start  = item_pop_o && (item_i.op == OP_QUERY);
  assign out_free   = !out_valid_q || out_ready_i;

  rrp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (item_i.slot),
    .divisor_i  (ring_len),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Ring position of this node in the round, and the found flag.
  always_comb begin
    qsum = (IDX_W+1)'(self_pos_q) + (IDX_W+1)'(r_q) - (IDX_W+1)'(1);
    if (qsum >= {1'b0, ring_len}) begin
      q_d = IDX_W'(qsum - {1'b0, ring_len});
    end else begin
      q_d = IDX_W'(qsum);
    end
    found_d = self_seen_q && ({1'b0, self_pos_q} < node_cnt);
  end

  // Table address of the partner and the direction of the exchange.
  always_comb begin
    tsum = {1'b0, q_q} + {1'b0, r_q};
    if (tsum >= {1'b0, ring_len}) begin
      t_red = IDX_W'(tsum - {1'b0, ring_len});
    end else begin
      t_red = IDX_W'(tsum);
    end
    if (self_pos_q == '0) begin
      // The hub meets the ring entry that rotates opposite to it.
      addr_d = (r_q == '0) ? IDX_W'(1) : node_cnt - r_q;
      dir_d  = 1'b0;
    end else if (q_q == '0) begin
      // The node that lands in the first ring place meets the hub.
      addr_d = '0;
      dir_d  = 1'b1;
    end else begin
      addr_d = (t_red == '0) ? IDX_W'(1) : node_cnt - t_red;
      dir_d  = (q_q < {1'b0, pc_eff}) ? 1'b0 : 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (rem_start) state_d = ST_DIV;
      ST_DIV:  if (rem_done) state_d = ST_QPOS;
      ST_QPOS: state_d = ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and self position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pair_count_q <= NODE_W'(1);
      self_id_q    <= '0;
      self_pos_q   <= '0;
      self_seen_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PAIR_COUNT: pair_count_q <= NODE_W'(cfg_wdata_i);
          CFG_SELF_ID: begin
            self_id_q   <= NODE_W'(cfg_wdata_i);
            self_seen_q <= 1'b0;
            self_pos_q  <= '0;
          end
          default: ;
        endcase
      end else if (do_load) begin
        if (item_i.value == self_id_q) begin
          self_pos_q  <= item_i.slot;
          self_seen_q <= 1'b1;
        end else if (self_seen_q && (item_i.slot == self_pos_q)) begin
          self_seen_q <= 1'b0;
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Query datapath registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV) && rem_done) begin
      r_q <= rem_val;
    end
    if (state_q == ST_QPOS) begin
      q_q     <= q_d;
      found_q <= found_d;
    end
    if (state_q == ST_ADDR) begin
      addr_q <= addr_d;
      dir_q  <= dir_d;
    end
    if ((state_q == ST_DONE) && out_free) begin
      partner_q   <= found_q ? rd_data_q : '0;
      dir_out_q   <= found_q && dir_q;
      found_out_q <= found_q;
    end
  end

  // Order table: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      table_mem[AW'(item_i.slot)] <= item_i.value;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= table_mem[AW'(addr_q)];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign partner_id_o = partner_q;
  assign direction_o  = dir_out_q;
  assign found_o      = found_out_q;

endmodule

// ----- rtl/round_robin_pairing_direct_top.sv -----
// ----------------------------------------------------------------------------
// round_robin_pairing_direct_top
// Round-robin pairing by the circle method, answered one round per query.
// ----------------------------------------------------------------------------
// A load word writes one node id into the order table and is retired when
// the execution side takes it; it gives no result. A query word passes
// through a dispatch step, the bit-serial remainder unit that reduces the
// round number modulo the ring size, and then position arithmetic, table
// read and result handoff; the execution side takes no new word until the
// query is through. A two-word queue sits in front and a result register
// behind, so words are taken while a result waits. Configure pair_count and
// self_id while the block is idle, and set self_id before loading the
// table.
// ----------------------------------------------------------------------------
module round_robin_pairing_direct_top import rrp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [NODE_W-1:0]     node_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NODE_W-1:0]     partner_id_o,
  output logic                  direction_o,
  output logic                  found_o
);

  logic  item_valid;
  item_t item;
  logic  item_pop;

  // Input side with queue.
  rrp_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .slot_i       (slot_i),
    .node_value_i (node_value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Execution side.
  rrp_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .partner_id_o (partner_id_o),
    .direction_o  (direction_o),
    .found_o      (found_o)
  );

endmodule

// ----- rtl/rrp_checker.sv -----
// ----------------------------------------------------------------------------
// rrp_props
// Port-level checks of the pairing block, bound to the top level.
// ----------------------------------------------------------------------------
module rrp_props import rrp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [NODE_W-1:0]     node_value_i,
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [NODE_W-1:0]     partner_id_o,
  input  logic                  direction_o,
  input  logic                  found_o
);

  logic [3:0] pending_q;
  logic       q_acc;
  logic       o_acc;

  assign q_acc = in_valid_i && in_ready_o && (op_e'(opcode_i) == OP_QUERY);
  assign o_acc = out_valid_o && out_ready_i;

  // Queries accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (q_acc && !o_acc) begin
      pending_q <= pending_q + 4'd1;
    end else if (o_acc && !q_acc) begin
      pending_q <= pending_q - 4'd1;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(partner_id_o)
      && $stable(direction_o) && $stable(found_o))
    else $error("result word changed while stalled");

  // Every result belongs to an accepted query.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without a pending query");

  // A miss reports partner zero and direction zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> partner_id_o == '0 && !direction_o)
    else $error("miss with nonzero partner or direction");

  // No result appears in the cycle after a query is taken while none is pending.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_acc && pending_q == 4'd0 && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // Configuration and load fields are not checked at this level.
  logic unused_ok;
  assign unused_ok = cfg_we_i ^ (^cfg_index_i) ^ (^cfg_wdata_i) ^ (^slot_i)
                     ^ (^node_value_i);

endmodule

bind round_robin_pairing_direct_top rrp_props u_rrp_props (.*);
